/* rtl/stoi_pkg.sv */
// ----------------------------------------------------------------------------
// stoi_pkg: shared types and constants of the string to integer parser
// Phase codes, parser state record, configuration record and character codes.
// ----------------------------------------------------------------------------
package stoi_pkg;

    // Widths of the value and the consumed-count arithmetic
    localparam int VALUE_WIDTH  = 64;
    localparam int OFFSET_WIDTH = 16;

    // Widths of the fixed port fields
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 6;
    localparam int VALUE_W    = 64;
    localparam int END_OFF_W  = 16;
    localparam int OUT_DATA_W = VALUE_W + END_OFF_W;
    localparam int DIGIT_W    = 6;

    // Base limits
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    // Digit value of a character that is no digit at all
    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd63;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'd88;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'd120;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'd122;

    // Configuration register indexes
    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_XMARK  = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase                    phase;
        logic                      neg;
        logic [BASE_W-1:0]         base;
        logic [VALUE_WIDTH-1:0]    acc;
        logic [OFFSET_WIDTH-1:0]   cnt;
    } t_state;

    typedef struct packed {
        logic [BASE_W-1:0] base_setting;
        logic              signed_mode;
    } t_cfg;

endpackage

/* rtl/stoi_cfg_regs.sv */
// ----------------------------------------------------------------------------
// stoi_cfg_regs: configuration registers
// Holds the base setting and the signed mode, written through the cfg channel.
// ----------------------------------------------------------------------------
module stoi_cfg_regs import stoi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [BASE_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_setting <= BASE_AUTO;
            r_cfg.signed_mode  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE:   r_cfg.base_setting <= i_cfg_data;
                REG_SIGNED: r_cfg.signed_mode  <= i_cfg_data[0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

/* rtl/stoi_step.sv */
// ----------------------------------------------------------------------------
// stoi_step: one-character parser step
// Next parser state and optional result for one character, pure logic.
// ----------------------------------------------------------------------------
module stoi_step import stoi_pkg::*; (
    input  t_state                  i_state,
    input  t_cfg                    i_cfg,
    input  logic [CHAR_W-1:0]       i_char,
    input  logic                    i_start,
    output t_state                  o_state,
    output logic                    o_emit,
    output logic [VALUE_WIDTH-1:0]  o_value,
    output logic [OFFSET_WIDTH-1:0] o_offset
);

    // Digit value 0..35, or NO_DIGIT
    function automatic logic [DIGIT_W-1:0] f_digit(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            d = DIGIT_W'(c - CH_UC_A + 8'd10);
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            d = DIGIT_W'(c - CH_LC_A + 8'd10);
        end
        return d;
    endfunction

    t_state                     s;
    logic                       stop;
    logic                       inc;
    logic                       is_space;
    logic                       is_x;
    logic [DIGIT_W-1:0]         digit;
    logic [VALUE_WIDTH+BASE_W-1:0] prod;

    assign is_space = (i_char inside {[CH_TAB:CH_CR], CH_SPACE});
    assign is_x     = (i_char == CH_LC_X) || (i_char == CH_UC_X);
    assign digit    = f_digit(i_char);
    // Multiply by the base currently in force (the base is settled by then)
    assign prod     = i_state.acc * i_state.base;

    always_comb begin
        s        = i_state;
        stop     = 1'b0;
        inc      = 1'b0;
        o_emit   = 1'b0;
        o_value  = '0;
        o_offset = '0;

        // Start of string: clear and latch the base, reject invalid bases
        if (i_start) begin
            s.phase = PH_SPACE;
            s.neg   = 1'b0;
            s.base  = i_cfg.base_setting;
            s.acc   = '0;
            s.cnt   = '0;
            if (s.base != BASE_AUTO && (s.base < BASE_MIN || s.base > BASE_MAX)) begin
                s.phase = PH_DONE;
                o_emit  = 1'b1;
                stop    = 1'b1;
            end
        end

        // Leading whitespace and sign
        if (!stop && s.phase == PH_SPACE) begin
            if (is_space) begin
                inc  = 1'b1;
                stop = 1'b1;
            end else begin
                s.phase = PH_PREFIX;
                if (i_cfg.signed_mode && (i_char == CH_PLUS || i_char == CH_MINUS)) begin
                    s.neg = (i_char == CH_MINUS);
                    inc   = 1'b1;
                    stop  = 1'b1;
                end
            end
        end

        // Optional leading zero of a prefix
        if (!stop && s.phase == PH_PREFIX) begin
            if ((s.base == BASE_AUTO || s.base == BASE_HEX) && i_char == CH_ZERO) begin
                inc     = 1'b1;
                s.phase = PH_XMARK;
                stop    = 1'b1;
            end else if (s.base == BASE_AUTO) begin
                s.base  = BASE_DEC;
                s.phase = PH_DIGITS;
            end else if (s.base == BASE_HEX) begin
                s.phase = PH_XMARK;
            end else begin
                s.phase = PH_DIGITS;
            end
        end

        // Optional x mark
        if (!stop && s.phase == PH_XMARK) begin
            s.phase = PH_DIGITS;
            if (is_x) begin
                if (s.base == BASE_AUTO) s.base = BASE_HEX;
                inc  = 1'b1;
                stop = 1'b1;
            end else if (s.base == BASE_AUTO) begin
                s.base = BASE_OCT;
            end
        end

        // Digits, or stop and report
        if (!stop && s.phase == PH_DIGITS) begin
            if (digit < s.base) begin
                // s.acc is unchanged here from i_state unless a start cleared it
                s.acc = i_start ? VALUE_WIDTH'(digit)
                                : VALUE_WIDTH'(prod) + VALUE_WIDTH'(digit);
                inc   = 1'b1;
            end else begin
                s.phase  = PH_DONE;
                o_emit   = 1'b1;
                o_value  = s.neg ? (~s.acc + 1'b1) : s.acc;
                o_offset = s.cnt;
            end
        end

        // Saturating count of consumed characters
        if (inc && s.cnt != '1) begin
            s.cnt = s.cnt + 1'b1;
        end

        o_state = s;
    end

endmodule

/* rtl/string_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// string_to_integer_parser: streaming strtol-style parser
// Path: the word that ends the string passes the input register, then one step
//   of logic into the output register, from which the result word leaves.
// Throughput: one character word per cycle, save while a word that makes a
//   result waits on a stalled output; the accumulator multiply-add sets the cycle.
// Reset: synchronous active-low i_rst_n clears the parser (whitespace phase,
//   auto base), the valid flags, base_setting to 0 and signed_mode to 1.
// ----------------------------------------------------------------------------
module string_to_integer_parser import stoi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input character stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [CHAR_W-1:0]     i_s_tdata,   // [7:0] char_code
    input  logic                  i_s_tuser,   // [0] start_of_string
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [63:0] value, [79:64] end_offset
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [BASE_W-1:0]     i_cfg_data
);

    t_cfg                    cfg;
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_in_valid;
    logic [CHAR_W-1:0]       r_in_char;
    logic                    r_in_start;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    emit;
    logic [VALUE_WIDTH-1:0]  step_value;
    logic [OFFSET_WIDTH-1:0] step_offset;
    logic                    out_free;
    logic                    advance;

    stoi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    stoi_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_char   (r_in_char),
        .i_start  (r_in_start),
        .o_state  (n_state),
        .o_emit   (emit),
        .o_value  (step_value),
        .o_offset (step_offset)
    );

    // A held word moves on unless it makes a result and the output is stuck
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign o_s_tready = !r_in_valid || advance;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char  <= i_s_tdata;
            r_in_start <= i_s_tuser;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_SPACE;
            r_state.neg   <= 1'b0;
            r_state.base  <= BASE_AUTO;
            r_state.acc   <= '0;
            r_state.cnt   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_data <= {END_OFF_W'(step_offset), VALUE_W'(step_value)};
        end
    end

    // A result that cannot leave keeps its character held
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && emit && r_out_valid && !i_m_tready)
        |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_start)))
        else $error("emitting character dropped while output stalled");

    // Every emitted result closes the string
    a_done_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_state.phase == PH_DONE && r_out_valid))
        else $error("parser not done after result");

    // Digit phase always runs with a real base
    a_digit_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_DIGITS) |-> (r_state.base >= BASE_MIN && r_state.base <= BASE_MAX))
        else $error("digit phase with invalid base");

endmodule
